/* design/lcd4_pkg.sv */
// Shared types, constants and the init command table for the 4-bit LCD driver.
`timescale 1ns / 1ps

package lcd4_pkg;

  localparam int unsigned WAIT_BITS_DEF = 20;
  localparam int unsigned CFG_W         = 20;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned Q_DEPTH       = 2;
  localparam int unsigned SETTLE_LIMIT  = 128;
  localparam int unsigned GUARD_W       = $clog2(SETTLE_LIMIT + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_EHIGH,
    PH_ESETTLE,
    PH_WAIT
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STROBE_HIGH = 3'd0,
    CFG_SETTLE      = 3'd1,
    CFG_POWERUP     = 3'd2,
    CFG_RESET_WAIT  = 3'd3,
    CFG_CLEAR_WAIT  = 3'd4
  } cfg_idx_t;

  // Init sequence steps
  localparam logic [STEP_W-1:0] STEP_POWERUP    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_NIB_RESET  = 5'd2;
  localparam logic [STEP_W-1:0] STEP_RESET_WAIT = 5'd3;
  localparam logic [STEP_W-1:0] STEP_STROBE_A   = 5'd4;
  localparam logic [STEP_W-1:0] STEP_STROBE_B   = 5'd6;
  localparam logic [STEP_W-1:0] STEP_NIB_4BIT   = 5'd8;
  localparam logic [STEP_W-1:0] STEP_CMD_FIRST  = 5'd10;
  localparam logic [STEP_W-1:0] STEP_CMD_LAST   = 5'd18;
  localparam logic [STEP_W-1:0] STEP_CLEAR_WAIT = 5'd19;
  localparam logic [STEP_W-1:0] STEP_LAST       = 5'd20;

  localparam logic [3:0] NIB_RESET = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  localparam logic [7:0]  RST_STROBE_HIGH = 8'd1;
  localparam logic [15:0] RST_SETTLE      = 16'd160;
  localparam logic [19:0] RST_POWERUP     = 20'd500000;
  localparam logic [15:0] RST_RESET_WAIT  = 16'd5000;
  localparam logic [15:0] RST_CLEAR_WAIT  = 16'd40000;

  typedef struct packed {
    op_t        kind;
    logic [7:0] byte_value;
    logic       is_data;
  } item_t;

  // Command byte sent at an even step of the command part of init
  function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] step);
    logic [7:0] c;
    case (step)
      5'd10:   c = 8'h28;
      5'd12:   c = 8'h10;
      5'd14:   c = 8'h06;
      5'd16:   c = 8'h0E;
      5'd18:   c = 8'h01;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/lcd4_ifs.sv */
// Handshake channels: command items in, pin status items out.
`timescale 1ns / 1ps

interface lcd4_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_value;
  logic       is_data;

  modport source (output valid, op, byte_value, is_data, input ready);
  modport sink   (input valid, op, byte_value, is_data, output ready);
endinterface

interface lcd4_pin_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_nibble;
  logic       rs_pin;
  logic       enable_pin;
  logic       backlight_pin;
  logic       busy_res;
  logic       ready_done;
  logic       rejected;

  modport source (output valid, data_nibble, rs_pin, enable_pin, backlight_pin, busy_res,
                  ready_done, rejected, input ready);
  modport sink   (input valid, data_nibble, rs_pin, enable_pin, backlight_pin, busy_res,
                  ready_done, rejected, output ready);
endinterface

/* design/lcd4_front.sv */
// Front stage: take command items, decode the op and register them for the queue.
`timescale 1ns / 1ps

module lcd4_front import lcd4_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  lcd4_cmd_if.sink cmd,
  output logic  f_valid,
  input  logic  f_ready,
  output item_t f_item
);

  item_t dec;

  always_comb begin
    dec.byte_value = cmd.byte_value;
    dec.is_data    = cmd.is_data;
    case (cmd.op)
      OP_TICK:  dec.kind = OP_TICK;
      OP_WRITE: dec.kind = OP_WRITE;
      OP_INIT:  dec.kind = OP_INIT;
      default:  dec.kind = OP_NONE;
    endcase
  end

  assign cmd.ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (cmd.ready) begin
      f_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      f_item <= dec;
    end
  end

endmodule

/* design/lcd4_queue.sv */
// Short item queue between the decode stage and the sequencer.
`timescale 1ns / 1ps

module lcd4_queue import lcd4_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  item_t            slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* design/lcd4_back.sv */
// Sequencer: apply items to the LCD timing state, chain zero-length waits, register results.
`timescale 1ns / 1ps

module lcd4_back import lcd4_pkg::*; #(
  parameter int unsigned WAIT_BITS = WAIT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  item_t                q_item,
  lcd4_pin_if.source           pins
);

  localparam logic [32:0] WAIT_MAX = (33'd1 << WAIT_BITS) - 33'd1;

  typedef struct packed {
    phase_t                phase;
    logic [STEP_W-1:0]     step;
    logic [WAIT_BITS-1:0]  wcnt;
    logic [7:0]            held;
    logic                  low_pend;
    logic [3:0]            nib;
    logic                  rs;
    logic                  en;
    logic                  bl;
    logic                  done;
  } eng_t;

  logic [7:0]         strobe_high_us;
  logic [15:0]        settle_us;
  logic [19:0]        powerup_us;
  logic [15:0]        reset_wait_us;
  logic [15:0]        clear_wait_us;

  eng_t               eng;
  eng_t               eng_next;
  logic               settling;
  logic               settling_next;
  logic [GUARD_W-1:0] guard;
  logic [GUARD_W-1:0] guard_next;

  eng_t               applied;
  eng_t               stepped;
  eng_t               out_src;
  logic               rej_a;
  logic               out_rej;
  logic               load_out;
  logic               slot_free;

  function automatic logic [WAIT_BITS-1:0] sat(input logic [19:0] v);
    logic [32:0] ext;
    ext = 33'(v);
    return (ext > WAIT_MAX) ? '1 : ext[WAIT_BITS-1:0];
  endfunction

  function automatic eng_t enter(input eng_t s, input phase_t ph, input logic [19:0] v);
    eng_t r;
    r       = s;
    r.phase = ph;
    r.wcnt  = sat(v);
    return r;
  endfunction

  function automatic eng_t strobe(input eng_t s);
    eng_t r;
    r    = s;
    r.en = 1'b1;
    return enter(r, PH_EHIGH, 20'(strobe_high_us));
  endfunction

  function automatic eng_t send_nibble(input eng_t s, input logic [3:0] n, input logic rs);
    eng_t r;
    r     = s;
    r.nib = n;
    r.rs  = rs;
    return strobe(r);
  endfunction

  function automatic eng_t send_byte(input eng_t s, input logic [7:0] b, input logic rs);
    eng_t r;
    r          = s;
    r.held     = b;
    r.low_pend = 1'b1;
    return send_nibble(r, b[7:4], rs);
  endfunction

  function automatic eng_t run_init(input eng_t s);
    eng_t r;
    r = s;
    if (s.step == STEP_POWERUP) begin
      r = enter(s, PH_WAIT, powerup_us);
    end else if (s.step == STEP_NIB_RESET) begin
      r = send_nibble(s, NIB_RESET, 1'b0);
    end else if (s.step == STEP_RESET_WAIT) begin
      r = enter(s, PH_WAIT, 20'(reset_wait_us));
    end else if (s.step == STEP_STROBE_A || s.step == STEP_STROBE_B) begin
      r = strobe(s);
    end else if (s.step == STEP_NIB_4BIT) begin
      r = send_nibble(s, NIB_4BIT, 1'b0);
    end else if (s.step >= STEP_CMD_FIRST && s.step <= STEP_CMD_LAST && !s.step[0]) begin
      r = send_byte(s, init_cmd(s.step), 1'b0);
    end else if (s.step == STEP_CLEAR_WAIT) begin
      r = enter(s, PH_WAIT, 20'(clear_wait_us));
    end else if (s.step >= STEP_LAST) begin
      r.bl    = 1'b1;
      r.done  = 1'b1;
      r.step  = '0;
      r.phase = PH_IDLE;
      r.wcnt  = '0;
    end else begin
      // odd steps between init commands
      r = enter(s, PH_WAIT, 20'(settle_us));
    end
    return r;
  endfunction

  function automatic eng_t next_action(input eng_t s);
    eng_t r;
    r = s;
    if (s.low_pend) begin
      r.low_pend = 1'b0;
      r = send_nibble(r, s.held[3:0], s.rs);
    end else if (s.step != '0) begin
      r.step = s.step + 1'b1;
      r = run_init(r);
    end else begin
      r.phase = PH_IDLE;
      r.wcnt  = '0;
    end
    return r;
  endfunction

  function automatic eng_t complete(input eng_t s);
    eng_t r;
    r = s;
    if (s.phase == PH_EHIGH) begin
      r.en = 1'b0;
      r = enter(r, PH_ESETTLE, 20'(settle_us));
    end else begin
      r = next_action(s);
    end
    return r;
  endfunction

  function automatic logic needs_step(input eng_t s);
    return (s.phase != PH_IDLE) && (s.wcnt == '0);
  endfunction

  // Apply the popped item
  always_comb begin
    applied = eng;
    rej_a   = 1'b0;
    case (q_item.kind)
      OP_TICK: begin
        if (eng.phase != PH_IDLE && eng.wcnt != '0) applied.wcnt = eng.wcnt - 1'b1;
      end
      OP_WRITE: begin
        if (eng.phase != PH_IDLE || !eng.done) rej_a = 1'b1;
        else applied = send_byte(eng, q_item.byte_value, q_item.is_data);
      end
      OP_INIT: begin
        if (eng.phase != PH_IDLE) begin
          rej_a = 1'b1;
        end else begin
          applied.done     = 1'b0;
          applied.nib      = '0;
          applied.rs       = 1'b0;
          applied.en       = 1'b0;
          applied.low_pend = 1'b0;
          applied.step     = STEP_POWERUP;
          applied = run_init(applied);
        end
      end
      default: ;
    endcase
  end

  assign stepped   = complete(eng);
  assign slot_free = !pins.valid || pins.ready;
  assign q_ready   = !settling && slot_free;

  always_comb begin
    eng_next      = eng;
    settling_next = settling;
    guard_next    = guard;
    load_out      = 1'b0;
    out_src       = eng;
    out_rej       = 1'b0;
    if (settling) begin
      if (!needs_step(eng) || guard == GUARD_W'(SETTLE_LIMIT)) begin
        // chain finished or guard limit reached: emit once the output slot frees
        if (slot_free) begin
          load_out      = 1'b1;
          settling_next = 1'b0;
        end
      end else begin
        eng_next   = stepped;
        guard_next = guard + 1'b1;
      end
    end else if (q_valid && q_ready) begin
      eng_next   = applied;
      guard_next = '0;
      if (needs_step(applied)) begin
        settling_next = 1'b1;
      end else begin
        load_out = 1'b1;
        out_src  = applied;
        out_rej  = rej_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eng.phase    <= PH_IDLE;
      eng.step     <= '0;
      eng.wcnt     <= '0;
      eng.held     <= '0;
      eng.low_pend <= 1'b0;
      eng.nib      <= '0;
      eng.rs       <= 1'b0;
      eng.en       <= 1'b0;
      eng.bl       <= 1'b0;
      eng.done     <= 1'b0;
      settling     <= 1'b0;
      guard        <= '0;
      pins.valid   <= 1'b0;
    end else begin
      eng      <= eng_next;
      settling <= settling_next;
      guard    <= guard_next;
      if (load_out)        pins.valid <= 1'b1;
      else if (pins.ready) pins.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pins.data_nibble   <= out_src.nib;
      pins.rs_pin        <= out_src.rs;
      pins.enable_pin    <= out_src.en;
      pins.backlight_pin <= out_src.bl;
      pins.busy_res      <= out_src.phase != PH_IDLE;
      pins.ready_done    <= out_src.done;
      pins.rejected      <= out_rej;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_high_us <= RST_STROBE_HIGH;
      settle_us      <= RST_SETTLE;
      powerup_us     <= RST_POWERUP;
      reset_wait_us  <= RST_RESET_WAIT;
      clear_wait_us  <= RST_CLEAR_WAIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STROBE_HIGH: strobe_high_us <= cfg_data[7:0];
        CFG_SETTLE:      settle_us      <= cfg_data[15:0];
        CFG_POWERUP:     powerup_us     <= cfg_data[19:0];
        CFG_RESET_WAIT:  reset_wait_us  <= cfg_data[15:0];
        CFG_CLEAR_WAIT:  clear_wait_us  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/char_lcd_nibble_interface.sv */
// Top level of the 4-bit character LCD driver.
//
// Channels: cmd carries items of op (tick, write byte, start init), byte_value
// and is_data; pins returns one item per command item with the pin levels
// (data_nibble, rs_pin, enable_pin, backlight_pin) and status (busy_res,
// ready_done, rejected) as they stand after that item. Each tick item is one
// microsecond of LCD time. Timing registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no item is in flight, the block does not enforce this.
//
// Path: an item passes the decode register (loaded at the accepting edge),
// the queue and the sequencer output register before its result is offered;
// a chain of zero-length waits adds a settling pass with one timing step per
// wait. Throughput: one item per cycle while no zero-length waits chain and
// the pins receiver takes results; the sequencer applies one timing step per cycle.
//
// Reset: sequencer pin state low, backlight off, not initialised, no result offered, timing registers at their
// defaults, queue empty. A stalled pins receiver holds the result register;
// the two-entry queue and decode register keep taking items until full.
`timescale 1ns / 1ps

module char_lcd_nibble_interface import lcd4_pkg::*; #(
  parameter int unsigned WAIT_BITS = WAIT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  lcd4_cmd_if.sink             cmd,
  lcd4_pin_if.source           pins,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  lcd4_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_item  (f_item)
  );

  lcd4_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  lcd4_back #(
    .WAIT_BITS (WAIT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .pins      (pins)
  );

endmodule

/* design/lcd4_checker.sv */
// Port-level checks for the LCD driver and their binding to the top level.
`timescale 1ns / 1ps

module lcd4_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic enable_pin,
  input logic backlight_pin,
  input logic busy_res,
  input logic ready_done,
  input logic rejected
);

  logic [3:0] outstanding;
  logic       bl_seen;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      bl_seen     <= 1'b0;
    end else begin
      outstanding <= outstanding + {3'd0, in_acc} - {3'd0, out_acc};
      if (out_acc && backlight_pin) bl_seen <= 1'b1;
    end
  end

  // no result without an item in flight
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 4'd0)
    else $error("result offered with no item in flight");

  // enable high only while a strobe is running
  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_pin |-> busy_res)
    else $error("enable high while idle");

  // an idle refusal can only come from a write before init
  a_reject_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected && !busy_res |-> !ready_done)
    else $error("idle item refused after init");

  // backlight never drops once on
  a_backlight_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && bl_seen |-> backlight_pin)
    else $error("backlight switched off");

endmodule

bind char_lcd_nibble_interface lcd4_checker u_lcd4_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (cmd.valid),
  .in_ready      (cmd.ready),
  .out_valid     (pins.valid),
  .out_ready     (pins.ready),
  .enable_pin    (pins.enable_pin),
  .backlight_pin (pins.backlight_pin),
  .busy_res      (pins.busy_res),
  .ready_done    (pins.ready_done),
  .rejected      (pins.rejected)
);
